FILE: hdl/zzd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag current deposit package
// Shared widths, register indexes, configuration record and the node offset
// table of the deposit pattern.
// ----------------------------------------------------------------------------
package zzd_pkg;

	localparam int DATA_W     = 32;
	localparam int NODE_W     = 11;
	localparam int CFL_W      = 17;
	localparam int CFL_FRAC   = 16;
	localparam int DEPOSITS   = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHARGE   = 3'd0,
		REG_COURANT  = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_ORIGIN_Z = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] charge;
		logic [CFL_W-1:0]         courant;
		logic signed [DATA_W-1:0] origin_x;
		logic signed [DATA_W-1:0] origin_y;
		logic signed [DATA_W-1:0] origin_z;
	} cfg_t;

	// Handshake between the front end and the queue.
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	// Bit 0 is the x offset, bit 1 y, bit 2 z.
	function automatic logic [2:0] node_offset(input logic [2:0] idx);
		logic [2:0] off;
		case (idx)
			3'd0:    off = 3'b000;
			3'd1:    off = 3'b001;
			3'd2:    off = 3'b010;
			3'd3:    off = 3'b100;
			3'd4:    off = 3'b110;
			3'd5:    off = 3'b101;
			3'd6:    off = 3'b011;
			default: off = 3'b000;
		endcase
		return off;
	endfunction

endpackage

FILE: hdl/zzd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle input channel
// Valid/ready channel carrying one particle position and proper velocity.
// ----------------------------------------------------------------------------
interface zzd_in_if;
	logic valid;
	logic ready;
	logic signed [zzd_pkg::DATA_W-1:0] pos_x;
	logic signed [zzd_pkg::DATA_W-1:0] pos_y;
	logic signed [zzd_pkg::DATA_W-1:0] pos_z;
	logic signed [zzd_pkg::DATA_W-1:0] vel_x;
	logic signed [zzd_pkg::DATA_W-1:0] vel_y;
	logic signed [zzd_pkg::DATA_W-1:0] vel_z;

	modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

FILE: hdl/zzd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deposit output channel
// Valid/ready channel carrying one node index and its current contribution.
// ----------------------------------------------------------------------------
interface zzd_out_if;
	logic valid;
	logic ready;
	logic [zzd_pkg::NODE_W-1:0]        node_x;
	logic [zzd_pkg::NODE_W-1:0]        node_y;
	logic [zzd_pkg::NODE_W-1:0]        node_z;
	logic signed [zzd_pkg::DATA_W-1:0] current_x;
	logic signed [zzd_pkg::DATA_W-1:0] current_y;
	logic signed [zzd_pkg::DATA_W-1:0] current_z;
	logic                              last;
	logic                              out_of_range;

	modport source(output valid, node_x, node_y, node_z, current_x, current_y, current_z,
		last, out_of_range, input ready);
	modport sink(input valid, node_x, node_y, node_z, current_x, current_y, current_z,
		last, out_of_range, output ready);
endinterface

FILE: hdl/zzd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag deposit front end
// Takes a particle, forms 1/gamma, the old position, the relay point, the
// segment fluxes and weights, and hands one record per particle to the queue.
// ----------------------------------------------------------------------------
module zzd_front #(
	parameter int GRID_CELLS = 1024,
	parameter int FRAC_BITS  = 16,
	parameter int QW         = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  zzd_pkg::cfg_t      cfg,
	zzd_in_if.sink             in_ch,
	output zzd_pkg::hs_t       push_hs_o,
	input  logic               push_ready,
	output logic [QW-1:0]      push_data
);

	localparam int F   = FRAC_BITS;
	localparam int DW  = zzd_pkg::DATA_W;
	localparam int XW  = $clog2(GRID_CELLS) + F;
	localparam int IW  = XW - F;
	localparam int WW  = F + 1;
	localparam int FW  = DW + XW + 2 - F;
	localparam int SW  = (XW + 2 > 36) ? XW + 2 : 36;
	localparam int CPW = zzd_pkg::CFL_W + WW;
	localparam logic signed [SW-1:0] TOP = SW'((longint'(GRID_CELLS) <<< F) - 1);
	localparam logic [zzd_pkg::CFL_W-1:0] CFL_ONE = zzd_pkg::CFL_W'(65536);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SQR   = 11'b000_0000_0010,
		ST_SUM   = 11'b000_0000_0100,
		ST_ROOT  = 11'b000_0000_1000,
		ST_DIV   = 11'b000_0001_0000,
		ST_CMUL  = 11'b000_0010_0000,
		ST_STEP  = 11'b000_0100_0000,
		ST_CLAMP = 11'b000_1000_0000,
		ST_RELAY = 11'b001_0000_0000,
		ST_FMUL  = 11'b010_0000_0000,
		ST_PUSH  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic signed [DW-1:0] pos_q [3];
	logic signed [DW-1:0] vel_q [3];
	logic signed [DW-1:0] org [3];
	logic [63:0]          sq_q [3];
	logic [63:0]          rem_q, root_q, bit_q;
	logic [63:0]          drem_q, ddiv_q;
	logic [WW-1:0]        quo_q;
	logic [4:0]           cnt_q;
	logic [WW-1:0]        c_q;
	logic signed [SW-1:0] step_q [3];
	logic signed [SW-1:0] p2_q [3];
	logic [2:0][XW-1:0]   x1_q, x2_q;
	logic                 clamped_q;
	logic signed [XW+1:0] d1_q [3];
	logic signed [XW+1:0] d2_q [3];
	logic [1:0][2:0][WW-1:0] w_q;
	logic [1:0][2:0][FW-1:0] f_q;

	// Combinational intermediates
	logic [63:0]          r_rem, r_root, r_bit;
	logic [63:0]          d_rem, d_div;
	logic [WW-1:0]        d_quo;
	logic [4:0]           d_cnt;
	logic [zzd_pkg::CFL_W-1:0] cfl_sat;
	logic [CPW-1:0]       cprod;
	logic signed [WW+DW:0] sprod [3];
	logic signed [SW-1:0] p1_c [3];
	logic [XW-1:0]        x1_c [3];
	logic [XW-1:0]        x2_c [3];
	logic [2:0]           oor_c;
	logic [2:0][IW-1:0]   i1_c, i2_c;
	logic [IW-1:0]        lo_c [3];
	logic [IW-1:0]        hi_c [3];
	logic [XW:0]          ra_c [3];
	logic [XW:0]          rb_c [3];
	logic [XW:0]          mid_c [3];
	logic [XW:0]          rel_c [3];
	logic [XW+1:0]        s1_c [3];
	logic [XW+1:0]        s2_c [3];
	logic signed [DW+XW+1:0] fp1 [3];
	logic signed [DW+XW+1:0] fp2 [3];

	function automatic logic [XW-1:0] clamp_pos(input logic signed [SW-1:0] v);
		if (v < 0)
			return '0;
		else if (v > TOP)
			return XW'(TOP);
		return XW'(v);
	endfunction

	assign org[0] = cfg.origin_x;
	assign org[1] = cfg.origin_y;
	assign org[2] = cfg.origin_z;

	assign in_ch.ready     = (state_q == ST_IDLE);
	assign push_hs_o.valid = (state_q == ST_PUSH);
	assign push_hs_o.ready = push_ready;
	assign push_data       = {clamped_q, i1_c, i2_c, f_q, w_q};

	// Four steps of the bitwise square root per cycle.
	always_comb begin
		r_rem  = rem_q;
		r_root = root_q;
		r_bit  = bit_q;
		for (int j = 0; j < 4; j++) begin
			if (r_rem >= r_root + r_bit) begin
				r_rem  = r_rem - (r_root + r_bit);
				r_root = (r_root >> 1) + r_bit;
			end else begin
				r_root = r_root >> 1;
			end
			r_bit = r_bit >> 2;
		end
	end

	// Up to four quotient bits of the restoring division per cycle.
	always_comb begin
		d_rem = drem_q;
		d_div = ddiv_q;
		d_quo = quo_q;
		d_cnt = cnt_q;
		for (int j = 0; j < 4; j++) begin
			if (d_cnt != 5'd0) begin
				if (d_rem >= d_div) begin
					d_rem = d_rem - d_div;
					d_quo = {d_quo[WW-2:0], 1'b1};
				end else begin
					d_quo = {d_quo[WW-2:0], 1'b0};
				end
				d_div = d_div >> 1;
				d_cnt = d_cnt - 5'd1;
			end
		end
	end

	assign cfl_sat = (cfg.courant > CFL_ONE) ? CFL_ONE : cfg.courant;
	assign cprod   = CPW'(cfl_sat) * CPW'(quo_q);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sprod[a] = $signed({1'b0, c_q}) * vel_q[a];
			p1_c[a]  = p2_q[a] - step_q[a];
			x1_c[a]  = clamp_pos(p1_c[a]);
			x2_c[a]  = clamp_pos(p2_q[a]);
			oor_c[a] = (p1_c[a] < 0) || (p1_c[a] > TOP) || (p2_q[a] < 0) || (p2_q[a] > TOP);
			i1_c[a]  = x1_q[a][XW-1:F];
			i2_c[a]  = x2_q[a][XW-1:F];
			lo_c[a]  = (i1_c[a] < i2_c[a]) ? i1_c[a] : i2_c[a];
			hi_c[a]  = (i1_c[a] < i2_c[a]) ? i2_c[a] : i1_c[a];
			ra_c[a]  = {({1'b0, lo_c[a]} + (IW+1)'(1)), {F{1'b0}}};
			rb_c[a]  = {1'b0, hi_c[a], {F{1'b0}}};
			mid_c[a] = (XW+1)'(({1'b0, x1_q[a]} + {1'b0, x2_q[a]}) >> 1);
			if (mid_c[a] > rb_c[a])
				rb_c[a] = mid_c[a];
			rel_c[a] = (ra_c[a] < rb_c[a]) ? ra_c[a] : rb_c[a];
			s1_c[a]  = (({2'b0, x1_q[a]} + {1'b0, rel_c[a]}) >> 1) - {2'b0, i1_c[a], {F{1'b0}}};
			s2_c[a]  = (({2'b0, x2_q[a]} + {1'b0, rel_c[a]}) >> 1) - {2'b0, i2_c[a], {F{1'b0}}};
			fp1[a]   = cfg.charge * d1_q[a];
			fp2[a]   = cfg.charge * d2_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid)
						state_q <= ST_SQR;
				end
				ST_SQR:  state_q <= ST_SUM;
				ST_SUM: begin
					cnt_q   <= 5'd8;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == 5'd1) begin
						cnt_q   <= 5'(WW);
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_DIV: begin
					cnt_q <= d_cnt;
					if (d_cnt == 5'd0)
						state_q <= ST_CMUL;
				end
				ST_CMUL:  state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_RELAY;
				ST_RELAY: state_q <= ST_FMUL;
				ST_FMUL:  state_q <= ST_PUSH;
				ST_PUSH: begin
					if (push_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pos_q[0] <= in_ch.pos_x;
				pos_q[1] <= in_ch.pos_y;
				pos_q[2] <= in_ch.pos_z;
				vel_q[0] <= in_ch.vel_x;
				vel_q[1] <= in_ch.vel_y;
				vel_q[2] <= in_ch.vel_z;
			end
			ST_SQR: begin
				for (int a = 0; a < 3; a++)
					sq_q[a] <= 64'(vel_q[a] * vel_q[a]);
			end
			ST_SUM: begin
				rem_q  <= (64'd1 << (2 * F)) + sq_q[0] + sq_q[1] + sq_q[2];
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
			end
			ST_ROOT: begin
				rem_q  <= r_rem;
				root_q <= r_root;
				bit_q  <= r_bit;
				drem_q <= 64'd1 << (2 * F);
				ddiv_q <= {32'd0, r_root[31:0]} << F;
				quo_q  <= '0;
			end
			ST_DIV: begin
				drem_q <= d_rem;
				ddiv_q <= d_div;
				quo_q  <= d_quo;
			end
			ST_CMUL: c_q <= WW'(cprod >> zzd_pkg::CFL_FRAC);
			ST_STEP: begin
				for (int a = 0; a < 3; a++) begin
					step_q[a] <= SW'(sprod[a] >>> F);
					p2_q[a]   <= SW'(pos_q[a]) - SW'(org[a]);
				end
			end
			ST_CLAMP: begin
				for (int a = 0; a < 3; a++) begin
					x1_q[a] <= x1_c[a];
					x2_q[a] <= x2_c[a];
				end
				clamped_q <= |oor_c;
			end
			ST_RELAY: begin
				for (int a = 0; a < 3; a++) begin
					d1_q[a]   <= $signed({1'b0, rel_c[a]}) - $signed({2'b0, x1_q[a]});
					d2_q[a]   <= $signed({2'b0, x2_q[a]}) - $signed({1'b0, rel_c[a]});
					w_q[0][a] <= WW'(s1_c[a]);
					w_q[1][a] <= WW'(s2_c[a]);
				end
			end
			ST_FMUL: begin
				for (int a = 0; a < 3; a++) begin
					f_q[0][a] <= FW'(fp1[a] >>> F);
					f_q[1][a] <= FW'(fp2[a] >>> F);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/zzd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag deposit particle queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module zzd_queue #(
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  zzd_pkg::hs_t push_hs,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int D  = zzd_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);

	logic [W-1:0] mem_q [D];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != (PW+1)'(D));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_hs.valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

endmodule

FILE: hdl/zzd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag deposit back end
// Walks the fourteen deposits of the particle at the queue head through a
// two-stage weight multiply and drives the result channel.
// ----------------------------------------------------------------------------
module zzd_back #(
	parameter int GRID_CELLS = 1024,
	parameter int FRAC_BITS  = 16,
	parameter int QW         = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [QW-1:0] q_data,
	output logic          q_pop,
	zzd_out_if.source     out_ch
);

	localparam int F  = FRAC_BITS;
	localparam int DW = zzd_pkg::DATA_W;
	localparam int NW = zzd_pkg::NODE_W;
	localparam int XW = $clog2(GRID_CELLS) + F;
	localparam int IW = XW - F;
	localparam int WW = F + 1;
	localparam int FW = DW + XW + 2 - F;
	localparam int TW = FW + 2;
	localparam int JW = TW + WW + 1;
	localparam logic [3:0] KLAST = 4'(zzd_pkg::DEPOSITS - 1);
	localparam logic [WW-1:0] ONE = WW'(1) << F;
	localparam logic signed [JW-1:0] SMAX = JW'(64'sd2147483647);
	localparam logic signed [JW-1:0] SMIN = JW'(-64'sd2147483648);

	logic                    hd_clamped;
	logic [2:0][IW-1:0]      hd_i1, hd_i2;
	logic [1:0][2:0][FW-1:0] hd_f;
	logic [1:0][2:0][WW-1:0] hd_w;

	logic [3:0] k_q;
	logic       en1, en2, fire;
	logic       seg;
	logic [2:0] off;
	logic [WW-1:0]        wt [3];
	logic [IW-1:0]        base [3];
	logic signed [TW+WW:0] tp [3];
	logic signed [JW-1:0]  jp [3];
	logic signed [JW-1:0]  js [3];

	logic                  v1_q, v2_q;
	logic [NW-1:0]         node_s1 [3];
	logic signed [TW-1:0]  t_s1 [3];
	logic [WW-1:0]         wt2_s1 [3];
	logic                  last_s1, oor_s1;
	logic [NW-1:0]         node_s2 [3];
	logic signed [DW-1:0]  cur_s2 [3];
	logic                  last_s2, oor_s2;

	assign {hd_clamped, hd_i1, hd_i2, hd_f, hd_w} = q_data;

	assign en2   = !v2_q || out_ch.ready;
	assign en1   = !v1_q || en2;
	assign fire  = q_valid && en1;
	assign q_pop = fire && (k_q == KLAST);

	assign seg = k_q[0];
	assign off = zzd_pkg::node_offset(k_q[3:1]);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			wt[a]   = off[a] ? hd_w[seg][a] : ONE - hd_w[seg][a];
			base[a] = seg ? hd_i2[a] : hd_i1[a];
		end
		for (int a = 0; a < 3; a++) begin
			tp[a] = $signed(hd_f[seg][a]) * $signed({1'b0, wt[(a == 2) ? 0 : a + 1]});
			jp[a] = (t_s1[a] * $signed({1'b0, wt2_s1[a]})) >>> F;
			if (jp[a] > SMAX)
				js[a] = SMAX;
			else if (jp[a] < SMIN)
				js[a] = SMIN;
			else
				js[a] = jp[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (fire)
				k_q <= (k_q == KLAST) ? '0 : k_q + 4'd1;
			if (en1)
				v1_q <= q_valid;
			if (en2)
				v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int a = 0; a < 3; a++) begin
				node_s1[a] <= NW'({1'b0, base[a]} + (IW+1)'(off[a]));
				// A component gets nothing on a node offset along its own axis.
				t_s1[a]    <= off[a] ? '0 : TW'(tp[a] >>> F);
				wt2_s1[a]  <= wt[(a == 0) ? 2 : a - 1];
			end
			last_s1 <= (k_q == KLAST);
			oor_s1  <= hd_clamped;
		end
		if (en2) begin
			for (int a = 0; a < 3; a++) begin
				node_s2[a] <= node_s1[a];
				cur_s2[a]  <= DW'(js[a]);
			end
			last_s2 <= last_s1;
			oor_s2  <= oor_s1;
		end
	end

	assign out_ch.valid        = v2_q;
	assign out_ch.node_x       = node_s2[0];
	assign out_ch.node_y       = node_s2[1];
	assign out_ch.node_z       = node_s2[2];
	assign out_ch.current_x    = cur_s2[0];
	assign out_ch.current_y    = cur_s2[1];
	assign out_ch.current_z    = cur_s2[2];
	assign out_ch.last         = last_s2;
	assign out_ch.out_of_range = oor_s2;

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n) k_q <= KLAST)
		else $error("deposit counter out of range");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (k_q == KLAST))
		else $error("queue popped before the last deposit");

	a_oor_same: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && v2_q && !last_s2) |-> (oor_s1 == oor_s2))
		else $error("range flag changed within one particle");

endmodule

FILE: hdl/zigzag_current_deposit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag current deposit
// First-order zigzag current deposition, one particle in, fourteen deposits
// out.
// ----------------------------------------------------------------------------
// Usage: a particle (position, proper velocity) enters on in_ch; fourteen
// deposits leave on out_ch, each a node index and three current components,
// the fourteenth marked by last. Every request of both channels completes
// when valid and ready are high at a rising clock edge.
// The user must write registers via cfg_we/cfg_index/cfg_data only while
// idle; the block does not enforce this. Indexes beyond four are ignored.
// The front end takes a new particle only after it has handed the record
// of the previous one to the queue: the square root runs four steps a
// cycle and the division up to four quotient bits a cycle. The back end
// then emits one deposit a cycle while out_ch is ready; the first deposit
// passes the back end's weight multiply stages after the record is written
// into the queue. A two-entry queue lets the front work on the next
// particle while the back still emits. When out_ch stalls, the back end
// holds its result and the queue fills before in_ch drops ready.
// Reset clears the queue and pipeline and loads charge 1.0, Courant 0.5
// and a zero origin.
// ----------------------------------------------------------------------------
module zigzag_current_deposit #(
	parameter int GRID_CELLS = 1024,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [zzd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [zzd_pkg::DATA_W-1:0]        cfg_data,
	zzd_in_if.sink                            in_ch,
	zzd_out_if.source                         out_ch
);

	localparam int F  = FRAC_BITS;
	localparam int XW = $clog2(GRID_CELLS) + F;
	localparam int IW = XW - F;
	localparam int WW = F + 1;
	localparam int FW = zzd_pkg::DATA_W + XW + 2 - F;
	localparam int QW = 1 + 6 * IW + 6 * FW + 6 * WW;

	zzd_pkg::cfg_t cfg_q;
	zzd_pkg::hs_t  push_hs;
	logic          push_ready;
	logic [QW-1:0] push_data;
	logic          q_valid, q_pop;
	logic [QW-1:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charge   <= 32'sd65536;
			cfg_q.courant  <= 17'd32768;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
		end else if (cfg_we) begin
			case (zzd_pkg::cfg_reg_t'(cfg_index))
				zzd_pkg::REG_CHARGE:   cfg_q.charge   <= cfg_data;
				zzd_pkg::REG_COURANT:  cfg_q.courant  <= cfg_data[zzd_pkg::CFL_W-1:0];
				zzd_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				zzd_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				zzd_pkg::REG_ORIGIN_Z: cfg_q.origin_z <= cfg_data;
				default: ;
			endcase
		end
	end

	zzd_front #(.GRID_CELLS(GRID_CELLS), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_ch      (in_ch),
		.push_hs_o  (push_hs),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	zzd_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_hs    (push_hs),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	zzd_back #(.GRID_CELLS(GRID_CELLS), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

FILE: dv/zzd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag current deposit checker
// Watches the configuration port and both channels, works out the fourteen
// deposits of every accepted particle and compares them, in order, with the
// deposits that the block delivers.
// ----------------------------------------------------------------------------
module zzd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	zzd_in_if           in_mon,
	zzd_out_if          out_mon,
	output int          fail_count,
	output int          outstanding
);

	localparam int     FRAC = 16;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint TOP_POS = (longint'(1024) << FRAC) - 1;

	typedef struct packed {
		logic [10:0] nx, ny, nz;
		logic [31:0] jx, jy, jz;
		logic        last;
		logic        oor;
	} deposit_t;

	deposit_t deposits_due[$];

	longint          charge_q;
	longint unsigned courant_q;
	longint          origin_q[3];

	function automatic logic [2:0] node_step(input int k);
		// Bit 0 is x, bit 1 y, bit 2 z.
		case (k)
			0: return 3'b000;
			1: return 3'b001;
			2: return 3'b010;
			3: return 3'b100;
			4: return 3'b110;
			5: return 3'b101;
			default: return 3'b011;
		endcase
	endfunction

	function automatic longint unsigned bit_sqrt(input longint unsigned n);
		longint unsigned rem, root, b;
		rem = n;
		root = 0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic longint fix_mul(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	task automatic predict_deposits(input logic signed [31:0] px, py, pz, vx, vy, vz);
		longint          pos[3], u[3], x1[3], x2[3], i1[3], i2[3], relay[3];
		longint          flux[2][3], wgt[2][3], wt[3], base[3];
		longint          p1, p2, lo, hi, ra, rb, mid, invgam, c, j;
		longint unsigned uu, cfl;
		logic            clamped;
		logic [2:0]      off;
		int              seg, b1, b2;
		logic [10:0]     nd[3];
		logic [31:0]     cur[3];
		deposit_t        d;
		pos[0] = px; pos[1] = py; pos[2] = pz;
		u[0] = vx; u[1] = vy; u[2] = vz;
		clamped = 1'b0;
		uu = 64'd1 << (2 * FRAC);
		for (int a = 0; a < 3; a++)
			uu = uu + longint'(u[a] * u[a]);
		cfl = (courant_q > 65536) ? 65536 : courant_q;
		invgam = longint'((64'd1 << (2 * FRAC)) / bit_sqrt(uu));
		c = (longint'(cfl) * invgam) >>> 16;
		for (int a = 0; a < 3; a++) begin
			p2 = pos[a] - origin_q[a];
			p1 = p2 - ((c * u[a]) >>> FRAC);
			if (p2 < 0) begin p2 = 0; clamped = 1'b1; end
			if (p2 > TOP_POS) begin p2 = TOP_POS; clamped = 1'b1; end
			if (p1 < 0) begin p1 = 0; clamped = 1'b1; end
			if (p1 > TOP_POS) begin p1 = TOP_POS; clamped = 1'b1; end
			x1[a] = p1;
			x2[a] = p2;
			i1[a] = p1 >>> FRAC;
			i2[a] = p2 >>> FRAC;
		end
		for (int a = 0; a < 3; a++) begin
			lo = (i1[a] < i2[a]) ? i1[a] : i2[a];
			hi = (i1[a] < i2[a]) ? i2[a] : i1[a];
			ra = (lo + 1) <<< FRAC;
			rb = hi <<< FRAC;
			mid = (x1[a] + x2[a]) >>> 1;
			if (mid > rb)
				rb = mid;
			relay[a] = (ra < rb) ? ra : rb;
			flux[0][a] = fix_mul(charge_q, relay[a] - x1[a]);
			flux[1][a] = fix_mul(charge_q, x2[a] - relay[a]);
			wgt[0][a] = ((x1[a] + relay[a]) >>> 1) - (i1[a] <<< FRAC);
			wgt[1][a] = ((x2[a] + relay[a]) >>> 1) - (i2[a] <<< FRAC);
		end
		for (int k = 0; k < 14; k++) begin
			off = node_step(k >> 1);
			seg = k & 1;
			for (int a = 0; a < 3; a++) begin
				base[a] = seg ? i2[a] : i1[a];
				wt[a] = off[a] ? wgt[seg][a] : ONE - wgt[seg][a];
				nd[a] = 11'(base[a] + off[a]);
			end
			for (int a = 0; a < 3; a++) begin
				b1 = (a + 1) % 3;
				b2 = (a + 2) % 3;
				j = 0;
				// No current flows along an axis on which the node is offset.
				if (!off[a])
					j = fix_mul(fix_mul(flux[seg][a], wt[b1]), wt[b2]);
				cur[a] = clip32(j);
			end
			d.nx = nd[0]; d.ny = nd[1]; d.nz = nd[2];
			d.jx = cur[0]; d.jy = cur[1]; d.jz = cur[2];
			d.last = (k == 13);
			d.oor = clamped;
			deposits_due.push_back(d);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deposit_t want, got;
		if (!arst_n) begin
			charge_q <= 65536;
			courant_q <= 32768;
			origin_q[0] <= 0;
			origin_q[1] <= 0;
			origin_q[2] <= 0;
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					zzd_pkg::REG_CHARGE:   charge_q <= longint'($signed(cfg_data));
					zzd_pkg::REG_COURANT:  courant_q <= cfg_data[16:0];
					zzd_pkg::REG_ORIGIN_X: origin_q[0] <= longint'($signed(cfg_data));
					zzd_pkg::REG_ORIGIN_Y: origin_q[1] <= longint'($signed(cfg_data));
					zzd_pkg::REG_ORIGIN_Z: origin_q[2] <= longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				predict_deposits(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z,
					in_mon.vel_x, in_mon.vel_y, in_mon.vel_z);
			if (out_mon.valid && out_mon.ready) begin
				got.nx = out_mon.node_x; got.ny = out_mon.node_y; got.nz = out_mon.node_z;
				got.jx = out_mon.current_x; got.jy = out_mon.current_y;
				got.jz = out_mon.current_z;
				got.last = out_mon.last;
				got.oor = out_mon.out_of_range;
				if (deposits_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected deposit, expected none, actual %h", $time, got);
				end else begin
					want = deposits_due.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: deposit mismatch node expected %0d,%0d,%0d actual %0d,%0d,%0d",
							$time, want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
						$display("%0t:   current expected %h %h %h actual %h %h %h",
							$time, want.jx, want.jy, want.jz, got.jx, got.jy, got.jz);
						$display("%0t:   last/clamp expected %b%b actual %b%b",
							$time, want.last, want.oor, got.last, got.oor);
					end
				end
			end
			outstanding = deposits_due.size();
		end
	end

endmodule

FILE: dv/zigzag_current_deposit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zigzag current deposit regression
// Drives particles in bursts under several register settings, stalls the
// deposit channel at random and once for a long stretch, and lets the
// checker compare every deposit against its own prediction.
// ----------------------------------------------------------------------------
module zigzag_current_deposit_test;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     SETTLE = 40;
	localparam longint SPAN = longint'(1024) << 16;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count;
	int          outstanding;
	int          cycles = 0;
	int          hold_requests;
	int          holds_done;

	zzd_in_if  in_ch();
	zzd_out_if out_ch();

	zigzag_current_deposit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	zzd_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("zigzag_current_deposit regression: fail");
			$finish;
		end
	end

	// Deposit side: random stall stretches, calm stretches and, on request,
	// one long hold-off so that the queue fills and the input stalls.
	initial begin
		int left, mode, hold;
		left = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else begin
				if (left == 0) begin
					left = $urandom_range(10, 60);
					mode = $urandom_range(0, 2);
				end
				left--;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default: out_ch.ready <= ($urandom_range(0, 1) != 0);
				endcase
			end
		end
	end

	task automatic write_regs(input logic [31:0] chg, cfl, ox, oy, oz);
		logic [31:0] vals[5];
		vals = '{chg, cfl, ox, oy, oz};
		// Wait for the block to drain before touching its registers.
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Offers one particle; a random gap may come first.
	task automatic send_particle(input logic [31:0] px, py, pz, vx, vy, vz);
		if ($urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pos_x <= px; in_ch.pos_y <= py; in_ch.pos_z <= pz;
		in_ch.vel_x <= vx; in_ch.vel_y <= vy; in_ch.vel_z <= vz;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	function automatic logic [31:0] lattice_pos(input logic [31:0] org);
		longint rel;
		case ($urandom_range(0, 9))
			0: rel = -longint'($urandom_range(1, 200000));
			1: rel = SPAN + $urandom_range(0, 200000);
			2: rel = longint'($urandom_range(0, 3)) << 16;
			default: rel = $urandom_range(0, 32'(SPAN - 1));
		endcase
		return 32'(longint'($signed(org)) + rel);
	endfunction

	function automatic logic [31:0] proper_vel();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 40000)) - 20000);
			default: return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
		endcase
	endfunction

	task automatic random_particles(input int n, input logic [31:0] ox, oy, oz);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_particle($urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom());
			else
				send_particle(lattice_pos(ox), lattice_pos(oy), lattice_pos(oz),
					proper_vel(), proper_vel(), proper_vel());
		end
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] ox, oy, oz;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_requests = 0;
		holds_done = 0;
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
		in_ch.vel_x = '0; in_ch.vel_y = '0; in_ch.vel_z = '0;
		out_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: corners of the lattice, both clamps, extreme velocities.
		send_particle(0, 0, 0, 0, 0, 0);
		send_particle(32'h03ff_ffff, 32'h03ff_ffff, 32'h03ff_ffff, 0, 0, 0);
		send_particle(32'h0400_0000, 32'h0000_8000, 32'h0001_0000, 0, 0, 0);
		send_particle(32'hffff_ffff, 32'h0001_8000, 32'h0002_4000, 0, 0, 0);
		send_particle(32'h8000_0000, 32'h7fff_ffff, 32'h0010_0000, 0, 0, 0);
		send_particle(32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_particle(32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_particle(32'h0000_4000, 32'h0020_c000, 32'h0100_0000,
			32'h0001_0000, 32'hfffe_0000, 32'h0000_8000);
		send_particle(32'h0002_0001, 32'h0003_ffff, 32'h0001_0000,
			32'hffff_0000, 32'h0003_0000, 32'h0000_0001);
		send_particle(32'h0000_0100, 32'h03ff_ff00, 32'h0200_8000,
			32'h0000_ffff, 32'hffff_ffff, 32'h7fff_ffff);
		in_ch.valid <= 1'b0;
		random_particles(20, 0, 0, 0);

		// Full-scale negative charge and a Courant number of exactly one.
		write_regs(32'h8000_0000, 32'd65536, 0, 0, 0);
		send_particle(0, 32'h0001_0000, 32'h0002_0000,
			32'h0002_0000, 32'hfffe_0000, 32'h0001_0000);
		send_particle(32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
		in_ch.valid <= 1'b0;
		random_particles(25, 0, 0, 0);

		// Courant number above one, largest charge, extreme origins.
		write_regs(32'h7fff_ffff, 32'h0001_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_particle(32'h7fff_ffff, 32'h8000_0000, 0, 32'h0001_0000, 0, 0);
		in_ch.valid <= 1'b0;
		random_particles(20, 32'h7fff_ffff, 32'h8000_0000, 0);

		// No step back at all; meanwhile the deposit side holds off for long.
		write_regs(32'hffff_0000, 0, 32'hfff0_0000, 32'h0001_0000, 32'h0abc_def1);
		hold_requests = hold_requests + 1;
		random_particles(25, 32'hfff0_0000, 32'h0001_0000, 32'h0abc_def1);

		// Random settings.
		for (int p = 0; p < 3; p++) begin
			ox = $urandom();
			oy = $urandom_range(0, 1) ? $urandom() : 0;
			oz = $urandom_range(0, 65535);
			write_regs($urandom(), $urandom_range(0, 70000), ox, oy, oz);
			random_particles(20, ox, oy, oz);
		end

		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("zigzag_current_deposit regression: pass");
		else
			$display("zigzag_current_deposit regression: fail");
		$finish;
	end

endmodule

FILE: files.f
hdl/zzd_pkg.sv
hdl/zzd_in_if.sv
hdl/zzd_out_if.sv
hdl/zzd_front.sv
hdl/zzd_queue.sv
hdl/zzd_back.sv
hdl/zigzag_current_deposit.sv
dv/zzd_checker.sv
dv/zigzag_current_deposit_test.sv
